@@ design/slpg_pkg.sv @@
// ============================================================================
// slpg_pkg
// Shared widths, register indexes and the run descriptor of the stride-lock
// prefetch generator.
// ============================================================================
package slpg_pkg;

    localparam int FRAME_W     = 31;
    localparam int STRIDE_W    = 32;
    localparam int WIN_W       = 7;
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 32;
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 64;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    // Largest prefetch distance; wider window settings are clamped to it.
    localparam logic [WIN_W-1:0] MAX_WINDOW = 7'd64;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_TOTAL_FRAMES    = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PREFETCH_WINDOW = 8'd1;

    // One prefetch run, handed from the classifier to the generator.
    typedef struct packed {
        logic [FRAME_W-1:0]         frame;      // requested frame
        logic signed [STRIDE_W-1:0] stride;     // stride used for the run
        logic [WIN_W-1:0]           stride_mag; // |stride|, clamped to MAX_WINDOW
        logic [WIN_W-1:0]           window;     // window, clamped to MAX_WINDOW
        logic                       locked;     // lock state after the request
    } run_desc_t;

endpackage

@@ design/slpg_front.sv @@
// ============================================================================
// slpg_front
// Request classifier: derives the stride, runs the lock machine and builds
// the run descriptor for each accepted request.
// ============================================================================
module slpg_front
    import slpg_pkg::*;
#(
    parameter int LOCK_LENGTH = 3
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [FRAME_W-1:0] in_frame,
    input  logic [WIN_W-1:0]   window_cfg,
    output logic               desc_valid,
    input  logic               desc_ready,
    output run_desc_t          desc
);

    localparam int CNT_W = $clog2(LOCK_LENGTH + 1);
    localparam logic [CNT_W-1:0] LOCK_MAX = CNT_W'(LOCK_LENGTH);

    logic [FRAME_W-1:0]         prev_frame_reg;
    logic signed [STRIDE_W-1:0] locked_stride_reg, locked_stride_next;
    logic signed [STRIDE_W-1:0] cand_stride_reg, cand_stride_next;
    logic [CNT_W-1:0]           hit_reg, hit_next;
    logic [CNT_W-1:0]           miss_reg, miss_next;
    logic                       locked_reg, locked_next;

    logic signed [STRIDE_W-1:0] diff;
    logic signed [STRIDE_W-1:0] stride;
    logic signed [STRIDE_W-1:0] run_stride;
    logic [STRIDE_W-1:0]        stride_abs;
    logic                       accept;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
        return (c >= LOCK_MAX) ? LOCK_MAX : c + 1'b1;
    endfunction

    assign in_ready   = desc_ready;
    assign desc_valid = in_valid;
    assign accept     = in_valid & desc_ready;

    always_comb
    begin
        diff   = $signed({1'b0, in_frame}) - $signed({1'b0, prev_frame_reg});
        stride = (diff == '0) ? STRIDE_W'(1) : diff;

        locked_stride_next = locked_stride_reg;
        cand_stride_next   = cand_stride_reg;
        hit_next           = hit_reg;
        miss_next          = miss_reg;
        locked_next        = locked_reg;

        if (locked_reg)
        begin
            if (locked_stride_reg == stride)
            begin
                hit_next  = '0;
                miss_next = '0;
            end
            else if (cand_stride_reg == stride)
            begin
                hit_next  = sat_inc(hit_reg);
                miss_next = sat_inc(miss_reg);
            end
            else
            begin
                hit_next  = '0;
                miss_next = sat_inc(miss_reg);
            end
            cand_stride_next = stride;
            // Relock onto the new stride once it has repeated long enough.
            if (miss_next >= LOCK_MAX && hit_next >= LOCK_MAX)
            begin
                locked_stride_next = stride;
                hit_next           = '0;
                miss_next          = '0;
            end
            else if (miss_next >= LOCK_MAX)
            begin
                locked_next = 1'b0;
            end
        end
        else
        begin
            // While unlocked the candidate stride is held, not followed.
            if (cand_stride_reg == stride)
            begin
                hit_next  = sat_inc(hit_reg);
                miss_next = '0;
            end
            else
            begin
                hit_next  = '0;
                miss_next = sat_inc(miss_reg);
            end
            if (hit_next >= LOCK_MAX)
            begin
                locked_stride_next = stride;
                miss_next          = '0;
                locked_next        = 1'b1;
            end
        end

        run_stride = locked_next ? locked_stride_next : STRIDE_W'(1);
        stride_abs = run_stride[STRIDE_W-1] ? STRIDE_W'(-run_stride) : STRIDE_W'(run_stride);

        desc.frame      = in_frame;
        desc.stride     = run_stride;
        desc.stride_mag = (stride_abs > STRIDE_W'(MAX_WINDOW)) ? MAX_WINDOW
                                                                : stride_abs[WIN_W-1:0];
        desc.window     = (window_cfg > MAX_WINDOW) ? MAX_WINDOW : window_cfg;
        desc.locked     = locked_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_frame_reg    <= '0;
            locked_stride_reg <= STRIDE_W'(1);
            cand_stride_reg   <= STRIDE_W'(1);
            hit_reg           <= '0;
            miss_reg          <= '0;
            locked_reg        <= 1'b0;
        end
        else if (accept)
        begin
            prev_frame_reg    <= in_frame;
            locked_stride_reg <= locked_stride_next;
            cand_stride_reg   <= cand_stride_next;
            hit_reg           <= hit_next;
            miss_reg          <= miss_next;
            locked_reg        <= locked_next;
        end
    end

endmodule

@@ design/slpg_queue.sv @@
// ============================================================================
// slpg_queue
// Two-entry queue of run descriptors between classifier and generator.
// ============================================================================
module slpg_queue
    import slpg_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push_valid,
    output logic      push_ready,
    input  run_desc_t push_desc,
    output logic      pop_valid,
    input  logic      pop_ready,
    output run_desc_t pop_desc
);

    run_desc_t         entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              do_push;
    logic              do_pop;

    assign push_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_desc   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid & push_ready;
    assign do_pop     = pop_valid & pop_ready;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_desc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

@@ design/slpg_back.sv @@
// ============================================================================
// slpg_back
// Candidate generator: walks one run at a time and emits one prefetch
// candidate per cycle through an output register while the output does not stall.
// ============================================================================
module slpg_back
    import slpg_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        desc_valid,
    output logic                        desc_ready,
    input  run_desc_t                   desc,
    input  logic [FRAME_W-1:0]          total_frames,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [FRAME_W-1:0]          out_frame,
    output logic                        out_last,
    output logic                        out_locked,
    output logic signed [STRIDE_W-1:0]  out_stride
);

    logic                       busy_reg;
    logic [FRAME_W-1:0]         cand_reg;
    logic [WIN_W-1:0]           dist_reg;
    logic signed [STRIDE_W-1:0] stride_reg;
    logic [WIN_W-1:0]           mag_reg;
    logic [WIN_W-1:0]           window_reg;
    logic                       locked_reg;

    logic                       out_valid_reg;
    logic [FRAME_W-1:0]         out_frame_reg;
    logic                       out_last_reg;
    logic                       out_locked_reg;
    logic signed [STRIDE_W-1:0] out_stride_reg;

    logic [FRAME_W+1:0]         first_sum;
    logic [FRAME_W+1:0]         next_sum;
    logic [WIN_W:0]             dist_sum;
    logic [WIN_W-1:0]           dist_next;
    logic                       first_ok;
    logic                       next_ok;
    logic                       load;
    logic                       emit;

    // A candidate is usable when it is non-negative and below the frame count.
    function automatic logic in_range(input logic [FRAME_W+1:0] x,
                                      input logic [FRAME_W-1:0] limit);
        return !x[FRAME_W+1] && (x[FRAME_W:0] < {1'b0, limit});
    endfunction

    assign desc_ready = !busy_reg;
    assign load       = desc_valid & !busy_reg;
    assign emit       = busy_reg & (!out_valid_reg | out_ready);

    always_comb
    begin
        first_sum = {2'b00, desc.frame} + {desc.stride[STRIDE_W-1], desc.stride};
        first_ok  = (desc.window != '0) && in_range(first_sum, total_frames);
        next_sum  = {2'b00, cand_reg} + {stride_reg[STRIDE_W-1], stride_reg};
        next_ok   = (dist_reg < window_reg) && in_range(next_sum, total_frames);
        dist_sum  = {1'b0, dist_reg} + {1'b0, mag_reg};
        dist_next = (dist_sum > {1'b0, MAX_WINDOW}) ? MAX_WINDOW : dist_sum[WIN_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                busy_reg <= first_ok;
            end
            else if (emit && !next_ok)
            begin
                busy_reg <= 1'b0;
            end
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            cand_reg   <= first_sum[FRAME_W-1:0];
            dist_reg   <= desc.stride_mag;
            stride_reg <= desc.stride;
            mag_reg    <= desc.stride_mag;
            window_reg <= desc.window;
            locked_reg <= desc.locked;
        end
        else if (emit)
        begin
            cand_reg <= next_sum[FRAME_W-1:0];
            dist_reg <= dist_next;
        end
        if (emit)
        begin
            out_frame_reg  <= cand_reg;
            out_last_reg   <= !next_ok;
            out_locked_reg <= locked_reg;
            out_stride_reg <= stride_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_frame  = out_frame_reg;
    assign out_last   = out_last_reg;
    assign out_locked = out_locked_reg;
    assign out_stride = out_stride_reg;

endmodule

@@ design/stride_lock_prefetch_generator_core.sv @@
// ============================================================================
// stride_lock_prefetch_generator_core
// Stride-locking frame prefetch generator with a streaming request input,
// a streaming candidate output and a small configuration write port.
// ============================================================================
// Each request item carries a frame number. The front end takes the stride
// from the previous request (a repeated frame counts as stride one), updates
// the lock machine in the cycle the item is accepted and queues a run
// descriptor; requests are taken one per cycle as long as the two-entry run
// queue has room. The back end turns each run into candidates n+s, n+2s, ...
// at one item per cycle while the output does not stall, where s is the
// locked stride, or one while unlocked. A run stops once the distance
// reaches the prefetch window (clamped to 64), or the next candidate would
// be negative or at or beyond total_frames; the last candidate of a run has
// tlast set, and a run may emit nothing at all. The generator loads a run
// in a step of its own and then spends one step on each candidate; it takes
// no new run until its last candidate has been emitted, and a run with no
// candidate holds the back end for the load step alone. No clearing pass is
// needed after reset. Configuration must be written only while the block is
// idle; the block itself does not enforce this.
// ============================================================================
module stride_lock_prefetch_generator_core
    import slpg_pkg::*;
#(
    parameter int LOCK_LENGTH = 3
)
(
    input  logic                   clk,
    input  logic                   rst_n,

    // Request stream. tdata: requested_frame [30:0], zero [31].
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,

    // Candidate stream. tdata: prefetch_frame [30:0], active_stride [62:31],
    // zero [63]. tuser: is_locked [0]. tlast: last_of_run.
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    output logic                   m_axis_tuser,
    output logic                   m_axis_tlast,

    // Configuration writes.
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    logic [FRAME_W-1:0]         total_frames_reg;
    logic [WIN_W-1:0]           window_reg;

    logic                       front_valid;
    logic                       front_ready;
    run_desc_t                  front_desc;
    logic                       queue_valid;
    logic                       queue_ready;
    run_desc_t                  queue_desc;

    logic [FRAME_W-1:0]         out_frame;
    logic signed [STRIDE_W-1:0] out_stride;

    // The configuration port never stalls.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_frames_reg <= '0;
            window_reg       <= 7'd8;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_TOTAL_FRAMES:    total_frames_reg <= cfg_data[FRAME_W-1:0];
                REG_PREFETCH_WINDOW: window_reg       <= cfg_data[WIN_W-1:0];
                default:             ;
            endcase
        end
    end

    // Front end: stride and lock classification.
    slpg_front #(
        .LOCK_LENGTH (LOCK_LENGTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_frame   (s_axis_tdata[FRAME_W-1:0]),
        .window_cfg (window_reg),
        .desc_valid (front_valid),
        .desc_ready (front_ready),
        .desc       (front_desc)
    );

    // Run queue decouples classification from candidate emission.
    slpg_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_desc  (front_desc),
        .pop_valid  (queue_valid),
        .pop_ready  (queue_ready),
        .pop_desc   (queue_desc)
    );

    // Back end: candidate walk and output register.
    slpg_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .desc_valid   (queue_valid),
        .desc_ready   (queue_ready),
        .desc         (queue_desc),
        .total_frames (total_frames_reg),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .out_frame    (out_frame),
        .out_last     (m_axis_tlast),
        .out_locked   (m_axis_tuser),
        .out_stride   (out_stride)
    );

    assign m_axis_tdata = {1'b0, out_stride, out_frame};

    // Inside a run, the next candidate follows directly after a taken one.
    a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid)
        else $error("candidate run broke off before its last item");

    // Every candidate shown lies inside the clip.
    a_within_clip: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[FRAME_W-1:0] < total_frames_reg))
        else $error("candidate at or beyond the frame count");

    // A run keeps one stride from its first candidate to its last.
    a_stride_held: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast
        |=> m_axis_tdata[62:31] == $past(m_axis_tdata[62:31]))
        else $error("stride changed within a run");

    // Unlocked runs always step by one frame.
    a_unlocked_unit: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |-> (m_axis_tdata[62:31] == 32'd1))
        else $error("unlocked run with a stride other than one");

endmodule

@@ tb/sv/tb.sv @@
// ----------------------------------------------------------------------------
// tb: stride-lock prefetch generator testbench
// Sends frame requests into the block and checks every prefetch candidate it
// returns against an in-bench model of the lock machine and the run
// generator. The two streams stall at random, the candidate side holds off
// once for a long stretch, and the two registers go through several
// settings between traffic phases, their extremes among them.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import slpg_pkg::*;

    localparam int     LOCK_LEN            = 3;
    localparam longint FRAME_MAX           = 64'h7FFF_FFFF;
    // Cycles allowed after the last expected item before the block counts as
    // idle. A run with no candidates can still be in flight at that point.
    localparam int     DRAIN_CYCLES        = 100;
    localparam int     BACKPRESSURE_CYCLES = 300;
    // Longest stretch in which no channel moves an item. The longest one in a
    // correct run is the single long hold-off of the candidate side.
    localparam int     STALL_LIMIT         = 2000;
    // Index that maps to no register; a write to it must change nothing.
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 8'hFF;

    // One expected prefetch candidate.
    typedef struct packed {
        logic [FRAME_W-1:0]         frame;
        logic signed [STRIDE_W-1:0] stride;
        logic                       locked;
        logic                       last;
    } prefetch_hint_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tuser;
    logic                   m_axis_tlast;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    // Requests waiting to be sent, and candidates waiting to come back.
    logic [FRAME_W-1:0] request_frames [$];
    prefetch_hint_t     expected_hints [$];
    int unsigned        fail_count = 0;

    // Mirror of the block's registers and of its lock machine.
    logic [FRAME_W-1:0]         frame_limit = '0;
    logic [WIN_W-1:0]           window_reg = 7'd8;
    logic [FRAME_W-1:0]         last_request = '0;
    logic signed [STRIDE_W-1:0] lock_stride = 32'sd1;
    logic signed [STRIDE_W-1:0] probe_stride = 32'sd1;
    logic [1:0]                 hit_run = '0;
    logic [1:0]                 miss_run = '0;
    logic                       lock_on = 1'b0;

    // Handshake seen at the last rising edge; the driver moves on after it.
    logic           req_fire = 1'b0;
    prefetch_hint_t want;

    // Traffic shaping state of the request and candidate sides.
    int unsigned send_gap = 0;
    int unsigned send_burst = 0;
    int unsigned send_pick;
    int unsigned sink_hold = 0;
    int unsigned sink_burst = 0;
    int unsigned sink_pick;
    logic        backpressure_req = 1'b0;
    logic        backpressure_done = 1'b0;
    longint      run_step = 1;

    stride_lock_prefetch_generator_core #(
        .LOCK_LENGTH(LOCK_LEN)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tlast (m_axis_tlast),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Saturating step of the hit and miss counters.
    function automatic logic [1:0] count_up(input logic [1:0] c);
        return (c >= LOCK_LEN) ? 2'(LOCK_LEN) : c + 2'd1;
    endfunction

    // Runs one request through the lock machine and queues the candidates it
    // yields. While unlocked the probe stride is frozen, so hits are counted
    // against the stride seen last while the lock was held.
    function automatic void predict_prefetch_run(input logic [FRAME_W-1:0] frame);
        longint                     n;
        longint                     delta;
        longint                     step;
        longint                     reach;
        longint                     cand;
        longint                     offset;
        logic signed [STRIDE_W-1:0] stride;
        int                         emitted;
        prefetch_hint_t             hint;

        n     = longint'(frame);
        delta = n - longint'(last_request);
        // A repeated frame counts as a forward stride of one.
        if (delta == 0)
            delta = 1;
        stride       = delta[STRIDE_W-1:0];
        last_request = frame;

        if (lock_on)
        begin
            if (lock_stride == stride)
            begin
                hit_run  = '0;
                miss_run = '0;
            end
            else if (probe_stride == stride)
            begin
                hit_run  = count_up(hit_run);
                miss_run = count_up(miss_run);
            end
            else
            begin
                hit_run  = '0;
                miss_run = count_up(miss_run);
            end
            probe_stride = stride;
            if (miss_run >= LOCK_LEN && hit_run >= LOCK_LEN)
            begin
                lock_stride = probe_stride;
                hit_run     = '0;
                miss_run    = '0;
            end
            else if (miss_run >= LOCK_LEN)
                lock_on = 1'b0;
        end
        else
        begin
            if (probe_stride == stride)
            begin
                hit_run  = count_up(hit_run);
                miss_run = '0;
            end
            else
            begin
                hit_run  = '0;
                miss_run = count_up(miss_run);
            end
            if (hit_run >= LOCK_LEN)
            begin
                lock_stride = stride;
                miss_run    = '0;
                lock_on     = 1'b1;
            end
        end

        step  = lock_on ? longint'(lock_stride) : 1;
        reach = (window_reg > MAX_WINDOW) ? longint'(MAX_WINDOW) : longint'(window_reg);

        // Walk n+s, n+2s, ... until the window is covered, the frame count is
        // reached or the candidate would go below frame zero.
        cand    = n;
        emitted = 0;
        forever
        begin
            offset = cand - n;
            if (offset < 0)
                offset = -offset;
            if (offset >= reach || emitted >= MAX_WINDOW)
                break;
            cand = cand + step;
            if (cand < 0 || cand >= longint'(frame_limit))
                break;
            hint.frame  = cand[FRAME_W-1:0];
            hint.stride = step[STRIDE_W-1:0];
            hint.locked = lock_on;
            hint.last   = 1'b0;
            expected_hints.push_back(hint);
            emitted++;
        end
        if (emitted > 0)
        begin
            hint      = expected_hints[expected_hints.size() - 1];
            hint.last = 1'b1;
            expected_hints[expected_hints.size() - 1] = hint;
        end
    endfunction

    // Request driver. A new item goes out at the falling edge once the last
    // one has been taken, unless a pause drawn after that item still runs.
    // Pauses are mostly short, now and then long, and bursts without any
    // pause come in between.
    always @(negedge clk)
    begin
        if (!s_axis_tvalid || req_fire)
        begin
            if (send_gap != 0)
            begin
                send_gap--;
                s_axis_tvalid <= 1'b0;
            end
            else if (request_frames.size() != 0)
            begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {1'b0, request_frames.pop_front()};
                if (send_burst != 0)
                    send_burst--;
                else
                begin
                    send_pick = $urandom_range(0, 99);
                    if (send_pick < 6)
                        send_burst = $urandom_range(10, 40);
                    else if (send_pick >= 92)
                        send_gap = $urandom_range(8, 40);
                    else if (send_pick >= 60)
                        send_gap = $urandom_range(1, 3);
                end
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // Candidate receiver. Besides its random stalls it holds off once for a
    // long stretch on request, so that the run queue fills and the request
    // side has to stall.
    always @(negedge clk)
    begin
        if (sink_hold != 0)
        begin
            sink_hold--;
            m_axis_tready <= 1'b0;
        end
        else if (backpressure_req && !backpressure_done)
        begin
            backpressure_done = 1'b1;
            sink_hold         = BACKPRESSURE_CYCLES - 1;
            m_axis_tready <= 1'b0;
        end
        else if (sink_burst != 0)
        begin
            sink_burst--;
            m_axis_tready <= 1'b1;
        end
        else
        begin
            sink_pick = $urandom_range(0, 99);
            if (sink_pick < 8)
            begin
                sink_burst = $urandom_range(20, 60);
                m_axis_tready <= 1'b1;
            end
            else if (sink_pick < 65)
                m_axis_tready <= 1'b1;
            else
            begin
                if (sink_pick < 93)
                    sink_hold = $urandom_range(0, 2);
                else
                    sink_hold = $urandom_range(8, 40);
                m_axis_tready <= 1'b0;
            end
        end
    end

    // Monitor. Everything is sampled at the rising edge: register writes and
    // requests update the model, and each candidate is checked field by
    // field against the oldest one still expected.
    always @(posedge clk)
    begin
        req_fire = s_axis_tvalid && s_axis_tready;

        if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == REG_TOTAL_FRAMES)
                frame_limit = cfg_data[FRAME_W-1:0];
            else if (cfg_index == REG_PREFETCH_WINDOW)
                window_reg = cfg_data[WIN_W-1:0];
        end

        if (req_fire)
            predict_prefetch_run(s_axis_tdata[FRAME_W-1:0]);

        if (m_axis_tvalid && m_axis_tready)
        begin
            if (expected_hints.size() == 0)
            begin
                $display("%0t: candidate expected none, actual frame %0d", $time,
                         m_axis_tdata[FRAME_W-1:0]);
                fail_count++;
            end
            else
            begin
                want = expected_hints.pop_front();
                if (m_axis_tdata[FRAME_W-1:0] !== want.frame)
                begin
                    $display("%0t: prefetch_frame expected %0d, actual %0d", $time,
                             want.frame, m_axis_tdata[FRAME_W-1:0]);
                    fail_count++;
                end
                if (m_axis_tdata[FRAME_W +: STRIDE_W] !== want.stride)
                begin
                    $display("%0t: active_stride expected %0d, actual %0d", $time,
                             want.stride, $signed(m_axis_tdata[FRAME_W +: STRIDE_W]));
                    fail_count++;
                end
                if (m_axis_tdata[OUT_TDATA_W-1] !== 1'b0)
                begin
                    $display("%0t: tdata pad bit expected 0, actual %b", $time,
                             m_axis_tdata[OUT_TDATA_W-1]);
                    fail_count++;
                end
                if (m_axis_tuser !== want.locked)
                begin
                    $display("%0t: is_locked expected %b, actual %b", $time,
                             want.locked, m_axis_tuser);
                    fail_count++;
                end
                if (m_axis_tlast !== want.last)
                begin
                    $display("%0t: last_of_run expected %b, actual %b", $time,
                             want.last, m_axis_tlast);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: ends the run once no channel has moved an item for too long.
    initial
    begin : watchdog
        int unsigned quiet;

        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("[stride_lock_prefetch_generator_core] ERROR");
        $finish;
    end

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Waits until every request is out and every candidate is back, then
    // gives runs that produce nothing time to leave the block.
    task automatic settle();
        while (request_frames.size() != 0 || s_axis_tvalid || expected_hints.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Queues random requests. Most of them form runs with a steady stride, so
    // the lock machine gets to lock, unlock and lock again; strides are
    // reused often because an unlocked machine only locks on the stride it
    // saw last while locked. Run starts lean toward frame zero and the frame count. The
    // rest is noise: random frames, the field extremes and repeated frames.
    task automatic queue_random_requests(input int unsigned count,
                                         input logic [FRAME_W-1:0] span);
        int unsigned        left;
        int unsigned        run_len;
        int unsigned        k;
        longint             base;
        longint             next_frame;
        logic [FRAME_W-1:0] last_queued;

        left        = count;
        last_queued = '0;
        while (left != 0)
        begin
            if ($urandom_range(0, 9) < 7)
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: ;
                    4: run_step = 1;
                    5: run_step = 2;
                    6: run_step = -3;
                    7: run_step = 4;
                    8: run_step = -1;
                    default:
                        run_step = $urandom_range(0, 1) ? longint'($urandom_range(1, 70))
                                                        : -longint'($urandom_range(1, 70));
                endcase
                case ($urandom_range(0, 3))
                    0: base = longint'($urandom_range(0, 100));
                    1: base = longint'(span) - longint'($urandom_range(1, 100));
                    default:
                        base = (span != 0) ? longint'($urandom_range(0, span - 1))
                                           : (longint'($urandom) & FRAME_MAX);
                endcase
                if (base < 0)
                    base = 0;
                if (base > FRAME_MAX)
                    base = FRAME_MAX;
                run_len = $urandom_range(3, 10);
                for (k = 0; k < run_len && left != 0; k++)
                begin
                    next_frame = base + longint'(k) * run_step;
                    if (next_frame < 0 || next_frame > FRAME_MAX)
                        break;
                    last_queued = next_frame[FRAME_W-1:0];
                    request_frames.push_back(last_queued);
                    left--;
                end
            end
            else
            begin
                case ($urandom_range(0, 4))
                    0: next_frame = longint'($urandom) & FRAME_MAX;
                    1: next_frame = 0;
                    2: next_frame = FRAME_MAX;
                    3: next_frame = longint'(last_queued);
                    default: next_frame = longint'(span);
                endcase
                last_queued = next_frame[FRAME_W-1:0];
                request_frames.push_back(last_queued);
                left--;
            end
        end
    endtask

    initial
    begin
        // Directed walk with a frame count of 1000 and a window of 8. It
        // locks on stride one, unlocks and relocks on +4, then on -4 runs
        // down to frame zero, where the run is cut short by the first
        // negative candidate and finally has no candidate at all. It ends
        // with the top frame, frame zero, and a request just below the
        // frame count.
        logic [FRAME_W-1:0] walk [22] = '{
            31'd6, 31'd7, 31'd8,
            31'd12, 31'd16, 31'd20, 31'd24, 31'd28, 31'd32, 31'd36,
            31'd32, 31'd28, 31'd24, 31'd20, 31'd16, 31'd12,
            31'd8, 31'd4, 31'd0,
            31'h7FFF_FFFF, 31'd0, 31'd995
        };
        logic [CFG_DATA_W-1:0] span;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset settings: the frame count is zero, so nothing may come back,
        // but the lock machine still moves. The second item repeats a frame.
        request_frames.push_back(31'd5);
        request_frames.push_back(31'd5);
        settle();

        write_reg(REG_TOTAL_FRAMES, 32'd1000);
        write_reg(REG_PREFETCH_WINDOW, 32'd8);
        foreach (walk[i])
            request_frames.push_back(walk[i]);
        settle();

        // Largest frame count (the top data bit is dropped) and full window.
        write_reg(REG_TOTAL_FRAMES, 32'hFFFF_FFFF);
        write_reg(REG_PREFETCH_WINDOW, 32'd64);
        queue_random_requests(20, 31'h7FFF_FFFF);
        settle();

        // A write to an unused index must leave both registers alone.
        write_reg(REG_SPARE, $urandom);
        queue_random_requests(6, 31'h7FFF_FFFF);
        settle();

        // A window of zero emits nothing at all.
        write_reg(REG_TOTAL_FRAMES, 32'd500);
        write_reg(REG_PREFETCH_WINDOW, 32'd0);
        queue_random_requests(16, 31'd500);
        settle();

        // Window above the limit is clamped to 64; the candidate side holds
        // off for a long stretch while the requests keep coming.
        span = {1'b1, 31'($urandom_range(2000, 1_000_000))};
        write_reg(REG_TOTAL_FRAMES, span);
        write_reg(REG_PREFETCH_WINDOW, 32'hFF);
        backpressure_req = 1'b1;
        queue_random_requests(24, span[FRAME_W-1:0]);
        settle();

        // Smallest window, then no frames at all.
        write_reg(REG_PREFETCH_WINDOW, 32'd1);
        queue_random_requests(10, span[FRAME_W-1:0]);
        settle();
        write_reg(REG_TOTAL_FRAMES, 32'd0);
        queue_random_requests(8, 31'd0);
        settle();

        // Small frame counts and windows, where all limits meet.
        span = $urandom_range(1, 300);
        write_reg(REG_TOTAL_FRAMES, span);
        write_reg(REG_PREFETCH_WINDOW, $urandom_range(1, 16));
        queue_random_requests(24, span[FRAME_W-1:0]);
        settle();

        if (fail_count == 0)
            $display("[stride_lock_prefetch_generator_core] OK");
        else
            $display("[stride_lock_prefetch_generator_core] ERROR");
        $finish;
    end

endmodule
